[rtl/tpu_pkg.sv]
// Shared types and constants for the tracker pattern unpacker.
// Used by tpu_parser, tpu_result_fifo and tracker_pattern_unpacker; no dependencies.
package tpu_pkg;

    localparam int BYTE_W     = 8;
    localparam int ROW_W      = 6;
    localparam int CHAN_W     = 5;
    localparam int PARTS_W    = 3;

    // Flag byte: data-present bits above the channel field
    localparam int FLAG_NOTE_BIT = 5;
    localparam int FLAG_VOL_BIT  = 6;
    localparam int FLAG_EFF_BIT  = 7;

    // Pending-parts bit positions (same order as the flag bits)
    localparam int PART_NOTE = 0;
    localparam int PART_VOL  = 1;
    localparam int PART_EFF  = 2;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_NOTE,
        PH_INSTR,
        PH_VOL,
        PH_EFF,
        PH_PARAM
    } phase_t;

    // One grid write
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [CHAN_W-1:0] chan;
        logic [BYTE_W-1:0] note;
        logic [BYTE_W-1:0] instr;
        logic [BYTE_W-1:0] vol;
        logic [BYTE_W-1:0] eff;
        logic [BYTE_W-1:0] param;
        logic              trunc;
        logic              last;
    } result_t;

    // Result pushes caused by one input beat
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

[rtl/tpu_parser.sv]
// Byte parser: phase, row counter and held event fields, plus result formation.
// Depends on tpu_pkg.
module tpu_parser #(
    parameter int ROWS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_fire,
    input  logic [tpu_pkg::BYTE_W-1:0] s_data_byte,
    input  logic                      s_final_byte,
    output tpu_pkg::push_t            push,
    output tpu_pkg::result_t          res0,
    output tpu_pkg::result_t          res1
);

    localparam int RW    = $clog2(ROWS + 1);
    localparam int EXT_W = RW + tpu_pkg::ROW_W;

    tpu_pkg::phase_t                  phase_reg, phase_next;
    logic [RW-1:0]                    row_reg, row_next;
    logic [tpu_pkg::PARTS_W-1:0]      pend_reg, pend_next;
    logic [tpu_pkg::CHAN_W-1:0]       chan_reg, chan_next;
    logic [tpu_pkg::BYTE_W-1:0]       note_reg, note_next;
    logic [tpu_pkg::BYTE_W-1:0]       instr_reg, instr_next;
    logic [tpu_pkg::BYTE_W-1:0]       vol_reg, vol_next;
    logic [tpu_pkg::BYTE_W-1:0]       eff_reg, eff_next;

    logic                             rows_done;
    logic                             flag_zero;
    logic                             tf_emit;
    logic                             tf_trunc;
    logic [EXT_W-1:0]                 row_ext;
    logic [tpu_pkg::ROW_W-1:0]        row_out;
    logic [tpu_pkg::PARTS_W-1:0]      flag_parts;

    // Flag byte decode
    assign rows_done  = (row_reg >= RW'(ROWS));
    assign flag_zero  = (s_data_byte == '0);
    assign flag_parts = s_data_byte[tpu_pkg::FLAG_EFF_BIT:tpu_pkg::FLAG_NOTE_BIT];
    // event written at once: no data parts, or the stream ends on the flag
    assign tf_emit    = !rows_done && !flag_zero && ((flag_parts == '0) || s_final_byte);
    assign tf_trunc   = s_data_byte[tpu_pkg::FLAG_NOTE_BIT] | s_data_byte[tpu_pkg::FLAG_VOL_BIT];
    assign row_ext    = EXT_W'(row_reg);
    assign row_out    = row_ext[tpu_pkg::ROW_W-1:0];

    // Next state
    always_comb begin
        phase_next = phase_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        chan_next  = chan_reg;
        note_next  = note_reg;
        instr_next = instr_reg;
        vol_next   = vol_reg;
        eff_next   = eff_reg;
        if (s_fire) begin
            case (phase_reg)
                tpu_pkg::PH_NOTE: begin
                    note_next  = s_data_byte;
                    phase_next = tpu_pkg::PH_INSTR;
                end
                tpu_pkg::PH_INSTR: begin
                    instr_next = s_data_byte;
                    if (pend_reg[tpu_pkg::PART_VOL]) begin
                        phase_next = tpu_pkg::PH_VOL;
                    end else if (pend_reg[tpu_pkg::PART_EFF]) begin
                        phase_next = tpu_pkg::PH_EFF;
                    end else begin
                        phase_next = tpu_pkg::PH_FLAG;
                    end
                end
                tpu_pkg::PH_VOL: begin
                    vol_next   = s_data_byte;
                    phase_next = pend_reg[tpu_pkg::PART_EFF] ? tpu_pkg::PH_EFF
                                                             : tpu_pkg::PH_FLAG;
                end
                tpu_pkg::PH_EFF: begin
                    eff_next   = s_data_byte;
                    phase_next = tpu_pkg::PH_PARAM;
                end
                tpu_pkg::PH_PARAM: begin
                    phase_next = tpu_pkg::PH_FLAG;
                end
                default: begin
                    if (!rows_done) begin
                        if (flag_zero) begin
                            row_next = row_reg + RW'(1);
                        end else begin
                            chan_next  = s_data_byte[tpu_pkg::CHAN_W-1:0];
                            note_next  = '0;
                            instr_next = '0;
                            vol_next   = '0;
                            eff_next   = '0;
                            pend_next  = flag_parts;
                            if (tf_emit) begin
                                phase_next = tpu_pkg::PH_FLAG;
                            end else if (flag_parts[tpu_pkg::PART_NOTE]) begin
                                phase_next = tpu_pkg::PH_NOTE;
                            end else if (flag_parts[tpu_pkg::PART_VOL]) begin
                                phase_next = tpu_pkg::PH_VOL;
                            end else begin
                                phase_next = tpu_pkg::PH_EFF;
                            end
                        end
                    end
                end
            endcase
            // last beat of the pattern: back to the reset state
            if (s_final_byte) begin
                phase_next = tpu_pkg::PH_FLAG;
                row_next   = '0;
                pend_next  = '0;
                chan_next  = '0;
                note_next  = '0;
                instr_next = '0;
                vol_next   = '0;
                eff_next   = '0;
            end
        end
    end

    // Result pushes and contents
    always_comb begin
        push        = '0;
        res0.row    = row_out;
        res0.chan   = chan_reg;
        res0.note   = (phase_reg == tpu_pkg::PH_NOTE)  ? s_data_byte : note_reg;
        res0.instr  = (phase_reg == tpu_pkg::PH_INSTR) ? s_data_byte : instr_reg;
        res0.vol    = (phase_reg == tpu_pkg::PH_VOL)   ? s_data_byte : vol_reg;
        res0.eff    = eff_reg;
        res0.param  = '0;
        res0.trunc  = 1'b0;
        res0.last   = 1'b1;
        // second write: a flag byte taken in place of a missing effect
        res1.row    = row_out;
        res1.chan   = s_data_byte[tpu_pkg::CHAN_W-1:0];
        res1.note   = '0;
        res1.instr  = '0;
        res1.vol    = '0;
        res1.eff    = '0;
        res1.param  = '0;
        res1.trunc  = tf_trunc;
        res1.last   = 1'b1;
        case (phase_reg)
            tpu_pkg::PH_NOTE: begin
                push.first = s_fire && s_final_byte;
                res0.trunc = 1'b1;
            end
            tpu_pkg::PH_INSTR: begin
                push.first = s_fire && (s_final_byte ||
                             (!pend_reg[tpu_pkg::PART_VOL] && !pend_reg[tpu_pkg::PART_EFF]));
                res0.trunc = s_final_byte && pend_reg[tpu_pkg::PART_VOL];
            end
            tpu_pkg::PH_VOL: begin
                push.first = s_fire && (s_final_byte || !pend_reg[tpu_pkg::PART_EFF]);
            end
            tpu_pkg::PH_EFF: begin
                push.first  = s_fire && s_final_byte;
                push.second = s_fire && s_final_byte && tf_emit;
                res0.last   = !(s_final_byte && tf_emit);
            end
            tpu_pkg::PH_PARAM: begin
                push.first = s_fire;
                res0.param = s_data_byte;
            end
            default: begin
                push.first  = s_fire && tf_emit;
                res0.chan   = s_data_byte[tpu_pkg::CHAN_W-1:0];
                res0.note   = '0;
                res0.instr  = '0;
                res0.vol    = '0;
                res0.eff    = '0;
                res0.trunc  = s_final_byte && tf_trunc;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tpu_pkg::PH_FLAG;
            row_reg   <= '0;
            pend_reg  <= '0;
            chan_reg  <= '0;
            note_reg  <= '0;
            instr_reg <= '0;
            vol_reg   <= '0;
            eff_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            chan_reg  <= chan_next;
            note_reg  <= note_next;
            instr_reg <= instr_next;
            vol_reg   <= vol_next;
            eff_reg   <= eff_next;
        end
    end

    // Checks
    a_final_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_final_byte |=> phase_reg == tpu_pkg::PH_FLAG && row_reg == '0)
        else $error("state not cleared after last beat");

    a_second_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        push.second |-> push.first)
        else $error("second result without first");

    a_second_only_eff_end: assert property (@(posedge aclk) disable iff (!aresetn)
        push.second |-> phase_reg == tpu_pkg::PH_EFF && s_final_byte)
        else $error("second result outside effect-skip case");

    a_event_within_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != tpu_pkg::PH_FLAG |-> row_reg < RW'(ROWS))
        else $error("event parsing past last row");

endmodule

[rtl/tpu_result_fifo.sv]
// Four-entry result queue: takes up to two results per cycle, delivers one on pop_ready.
// Depends on tpu_pkg.
module tpu_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  tpu_pkg::push_t    push,
    input  tpu_pkg::result_t  din0,
    input  tpu_pkg::result_t  din1,
    input  logic              pop_ready,
    output logic              out_valid,
    output tpu_pkg::result_t  dout,
    output logic              space_ok
);

    tpu_pkg::result_t                mem [tpu_pkg::FIFO_DEPTH];
    logic [tpu_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tpu_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tpu_pkg::FIFO_CNT_W-1:0]  count_reg, count_next;
    logic [tpu_pkg::FIFO_PTR_W-1:0]  wr_ptr_plus1;
    logic                            pop_fire;

    assign out_valid    = (count_reg != '0);
    assign dout         = mem[rd_ptr_reg];
    assign pop_fire     = out_valid && pop_ready;
    // room for the worst case of two results from one beat
    assign space_ok     = (count_reg <= tpu_pkg::FIFO_CNT_W'(tpu_pkg::FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + tpu_pkg::FIFO_PTR_W'(1);

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + tpu_pkg::FIFO_PTR_W'(push.first)
                                 + tpu_pkg::FIFO_PTR_W'(push.second);
        rd_ptr_next = rd_ptr_reg + tpu_pkg::FIFO_PTR_W'(pop_fire);
        count_next  = count_reg + tpu_pkg::FIFO_CNT_W'(push.first)
                                + tpu_pkg::FIFO_CNT_W'(push.second)
                                - tpu_pkg::FIFO_CNT_W'(pop_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push.first) begin
            mem[wr_ptr_reg] <= din0;
        end
        if (push.second) begin
            mem[wr_ptr_plus1] <= din1;
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tpu_pkg::FIFO_CNT_W'(tpu_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.first |-> space_ok)
        else $error("push while queue lacks room");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.second |-> push.first)
        else $error("second push without first");

endmodule

[rtl/tracker_pattern_unpacker.sv]
// Top level of the packed pattern unpacker: parser feeding a result queue.
// Depends on tpu_pkg, tpu_parser and tpu_result_fifo.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    data_byte[7:0], final_byte
//  m_        out        m_valid/m_ready    row, channel, note, instrument, volume,
//                                          effect, param, truncated, last_of_run
//
// One byte is accepted per cycle; its results are queued the same edge, and an
// empty queue offers the first on m_ the next cycle. A byte yields zero, one or
// two results. s_ready stays high while the four-entry result queue has two free
// slots, so m_, taking one result per cycle on m_ready, sets the sustained rate.
// Synchronous active-low reset clears the parser and empties the queue.
module tracker_pattern_unpacker #(
    parameter int ROWS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [tpu_pkg::BYTE_W-1:0] s_data_byte,
    input  logic                       s_final_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tpu_pkg::ROW_W-1:0]  m_row_index,
    output logic [tpu_pkg::CHAN_W-1:0] m_channel_index,
    output logic [tpu_pkg::BYTE_W-1:0] m_note_value,
    output logic [tpu_pkg::BYTE_W-1:0] m_instrument_value,
    output logic [tpu_pkg::BYTE_W-1:0] m_volume_value,
    output logic [tpu_pkg::BYTE_W-1:0] m_effect_value,
    output logic [tpu_pkg::BYTE_W-1:0] m_effect_param,
    output logic                       m_truncated,
    output logic                       m_last_of_run
);

    logic              s_fire;
    tpu_pkg::push_t    push;
    tpu_pkg::result_t  res0;
    tpu_pkg::result_t  res1;
    tpu_pkg::result_t  head;

    assign s_fire = s_valid && s_ready;

    // Byte parser
    tpu_parser #(
        .ROWS (ROWS)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_fire       (s_fire),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .push         (push),
        .res0         (res0),
        .res1         (res1)
    );

    // Result queue
    tpu_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .din0      (res0),
        .din1      (res1),
        .pop_ready (m_ready),
        .out_valid (m_valid),
        .dout      (head),
        .space_ok  (s_ready)
    );

    // Result beat fields
    assign m_row_index        = head.row;
    assign m_channel_index    = head.chan;
    assign m_note_value       = head.note;
    assign m_instrument_value = head.instr;
    assign m_volume_value     = head.vol;
    assign m_effect_value     = head.eff;
    assign m_effect_param     = head.param;
    assign m_truncated        = head.trunc;
    assign m_last_of_run      = head.last;

endmodule
